@@ sv/grid_flow_direction_accumulator_core_macros.svh @@
// assertion macros for the grid flow direction accumulator checker
// expects clk and rst in the scope of use
`ifndef GRID_FLOW_DIRECTION_ACCUMULATOR_CORE_MACROS_SVH
`define GRID_FLOW_DIRECTION_ACCUMULATOR_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define GFDA_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication checked in the cycle after the antecedent
`define GFDA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/gfda_pkg.sv @@
// shared types, codes, constants and the cordic angle table
// used by every module of the grid flow direction accumulator
package gfda_pkg;

  localparam int GRID_COLUMNS_DEF = 64;
  localparam int GRID_ROWS_DEF    = 64;
  localparam int FLOW_BITS_DEF    = 14;

  localparam int CELL_COORD_W = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int THR_W        = 13;
  localparam int COUNT_W      = 8;
  localparam int TOTAL_W      = 13;
  localparam int RATIO_W      = 8;
  localparam int DIR_W        = 15;
  localparam int FIN_W        = 13;

  localparam int CORDIC_STEPS = 20;
  localparam int ITER_W       = 5;
  localparam int ANGLE_W      = 32;
  localparam logic [ANGLE_W-1:0] QUARTER = 32'd377487360;
  localparam logic [16:0] TURN_UNITS = 17'd23040;
  localparam logic [FIN_W-1:0] FINISHED_MAX = 13'd8191;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINISH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGIVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENT    = 3'd5;

  localparam logic [THR_W-1:0]   THR_RESET     = 13'd256;
  localparam logic [COUNT_W-1:0] FINISH_RESET  = 8'd30;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 13'd4096;
  localparam logic [RATIO_W-1:0] STOP_RESET    = 8'd230;
  localparam logic [RATIO_W-1:0] FORGIVE_RESET = 8'd128;
  localparam logic [RATIO_W-1:0] ABSENT_RESET  = 8'd26;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    CLS_COLLECT, CLS_KNOWN, CLS_UNKNOWN, CLS_NOT_ROAD
  } cell_class_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EVAL, ST_CORDIC, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic eval;
    logic cordic_step;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_dir;
    logic cordic_done;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) in degrees scaled by 2^22
  function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic signed [ANGLE_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/grid_flow_direction_accumulator_core.sv @@
// Grid flow direction accumulator. After reset the cell memory is swept to zero, one cell per
// cycle, over all GRID_COLUMNS*GRID_ROWS cells (4096 by default) while in_stall stays high;
// configuration writes are taken throughout. One item is worked at a time: a sample that leaves
// its cell collecting, a classify that gives no direction, and any cell outside the grid pass
// three steps (accept with memory read, update and write back, result register), set by the
// read-modify-write of the cell memory. When a direction is reported, the shared cordic unit
// adds up to 20 rotation steps and an angle folding step before the result register.
// A finished result waits in the output register while the next item is accepted.
module grid_flow_direction_accumulator_core import gfda_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int FLOW_BITS    = FLOW_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [CELL_COORD_W-1:0]     cell_x,
  input  logic [CELL_COORD_W-1:0]     cell_y,
  input  logic signed [FLOW_BITS-1:0] flow_x,
  input  logic signed [FLOW_BITS-1:0] flow_y,
  input  logic                        cell_is_road,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  cell_class,
  output logic [DIR_W-1:0]            direction,
  output logic [FIN_W-1:0]            road_cells_finished,
  output logic                        stop_reached,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  gfda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gfda_dp #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .FLOW_BITS    (FLOW_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .command             (command),
    .cell_x              (cell_x),
    .cell_y              (cell_y),
    .flow_x              (flow_x),
    .flow_y              (flow_y),
    .cell_is_road        (cell_is_road),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .cell_class          (cell_class),
    .direction           (direction),
    .road_cells_finished (road_cells_finished),
    .stop_reached        (stop_reached)
  );

endmodule

@@ sv/gfda_ctrl.sv @@
// controller state machine of the grid flow direction accumulator
// depends on gfda_pkg for state, command and status types
module gfda_ctrl import gfda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_EVAL;
      ST_EVAL:   state_next = status.need_dir ? ST_CORDIC : ST_OUT;
      ST_CORDIC: if (status.cordic_done) state_next = ST_FIN;
      ST_FIN:    state_next = ST_OUT;
      ST_OUT:    if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR:  cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EVAL:   cmd.eval = 1'b1;
      ST_CORDIC: cmd.cordic_step = 1'b1;
      ST_FIN:    cmd.finish = 1'b1;
      ST_OUT:    cmd.out_load = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

@@ sv/gfda_dp.sv @@
// datapath: config registers, cell memory, sample update, cordic unit, result register
// depends on gfda_pkg; driven by gfda_ctrl through ctrl_cmd_t
module gfda_dp import gfda_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int FLOW_BITS    = FLOW_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_cmd_t                   cmd,
  output dp_status_t                  status,
  input  logic                        command,
  input  logic [CELL_COORD_W-1:0]     cell_x,
  input  logic [CELL_COORD_W-1:0]     cell_y,
  input  logic signed [FLOW_BITS-1:0] flow_x,
  input  logic signed [FLOW_BITS-1:0] flow_y,
  input  logic                        cell_is_road,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [1:0]                  cell_class,
  output logic [DIR_W-1:0]            direction,
  output logic [FIN_W-1:0]            road_cells_finished,
  output logic                        stop_reached
);

  localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SUM_W   = FLOW_BITS + 8;
  localparam int SQ_W    = 2 * FLOW_BITS;
  localparam int MAG_W   = SQ_W + 1;
  localparam int THR2_W  = 2 * THR_W;
  localparam int MC_W    = (MAG_W > THR2_W) ? MAG_W : THR2_W;
  localparam int ENTRY_W = 2 * SUM_W + COUNT_W;
  localparam int CW      = SUM_W + 26;
  localparam int PROD_W  = COUNT_W + RATIO_W;
  localparam int STOPP_W = RATIO_W + TOTAL_W;

  // configuration
  logic [THR_W-1:0]   thr;
  logic [COUNT_W-1:0] finish;
  logic [TOTAL_W-1:0] total;
  logic [RATIO_W-1:0] stop_ratio, grace_ratio, absent_ratio;
  logic [THR2_W-1:0]  thr2;
  logic [PROD_W-1:0]  forgive_prod, absent_prod;
  logic [STOPP_W-1:0] stop_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      finish <= FINISH_RESET;
      total <= TOTAL_RESET;
      stop_ratio <= STOP_RESET;
      grace_ratio <= FORGIVE_RESET;
      absent_ratio <= ABSENT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr <= cfg_data[THR_W-1:0];
        CFG_FINISH:    finish <= cfg_data[COUNT_W-1:0];
        CFG_TOTAL:     total <= cfg_data[TOTAL_W-1:0];
        CFG_STOP:      stop_ratio <= cfg_data[RATIO_W-1:0];
        CFG_FORGIVE:   grace_ratio <= cfg_data[RATIO_W-1:0];
        CFG_ABSENT:    absent_ratio <= cfg_data[RATIO_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr2 <= thr * thr;
    forgive_prod <= finish * grace_ratio;
    absent_prod <= finish * absent_ratio;
    stop_prod <= stop_ratio * total;
  end

  // input capture and squares
  logic [ADDR_W-1:0]       in_idx, addr_r, clr_addr;
  logic                    in_grid, grid_r, cmd_r, road_r;
  logic signed [FLOW_BITS-1:0] fx_r, fy_r;
  logic signed [SQ_W-1:0]  fxe, fye;
  logic [SQ_W-1:0]         sqx, sqy;

  assign in_idx  = ADDR_W'(int'(cell_y) * GRID_COLUMNS + int'(cell_x));
  assign in_grid = (int'(cell_x) < GRID_COLUMNS) && (int'(cell_y) < GRID_ROWS);
  assign fxe = SQ_W'(flow_x);
  assign fye = SQ_W'(flow_y);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_idx;
      grid_r <= in_grid;
      cmd_r  <= command;
      road_r <= cell_is_road;
      fx_r   <= flow_x;
      fy_r   <= flow_y;
      sqx    <= fxe * fxe;
      sqy    <= fye * fye;
    end
  end

  // cell memory
  logic [ENTRY_W-1:0] mem [CELLS];
  logic [ENTRY_W-1:0] mem_q, wd;
  logic [ADDR_W-1:0]  wa;
  logic               we, write_ok;

  always_ff @(posedge clk) begin
    if (cmd.accept) mem_q <= mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // sample evaluation
  logic signed [SUM_W-1:0] sh, sv, sh_n, sv_n;
  logic [COUNT_W-1:0]      cnt, cnt_n;
  logic [MAG_W-1:0]        mag2;
  logic                    counted, completes, known, classify;
  logic [PROD_W-1:0]       scaled;
  cell_class_t             cls_eval, cls_r;
  logic [FIN_W-1:0]        fin, fin_inc;
  logic                    stop;

  assign sh  = mem_q[ENTRY_W-1 -: SUM_W];
  assign sv  = mem_q[COUNT_W +: SUM_W];
  assign cnt = mem_q[COUNT_W-1:0];
  assign mag2 = {1'b0, sqx} + {1'b0, sqy};
  assign classify = (cmd_r == CMD_CLASSIFY);
  assign counted = !classify && (cnt < finish) && (MC_W'(mag2) > MC_W'(thr2));
  assign sh_n  = counted ? sh + SUM_W'(fx_r) : sh;
  assign sv_n  = counted ? sv + SUM_W'(fy_r) : sv;
  assign cnt_n = counted ? cnt + 1'b1 : cnt;
  assign completes = grid_r && counted && (cnt_n == finish) && road_r;
  assign scaled = {cnt, 8'b0};
  assign fin_inc = (fin < FINISHED_MAX) ? fin + 1'b1 : fin;

  always_comb begin
    cls_eval = CLS_COLLECT;
    if (grid_r) begin
      if (!classify) begin
        cls_eval = (cnt_n >= finish) ? CLS_KNOWN : CLS_COLLECT;
      end else if (scaled > forgive_prod) begin
        cls_eval = CLS_KNOWN;
      end else if (scaled < absent_prod) begin
        cls_eval = CLS_NOT_ROAD;
      end else begin
        cls_eval = CLS_UNKNOWN;
      end
    end
  end

  assign known = (cls_eval == CLS_KNOWN);
  assign write_ok = grid_r && counted;
  assign we = cmd.clear_en || (cmd.eval && write_ok);
  assign wa = cmd.clear_en ? clr_addr : addr_r;
  assign wd = cmd.clear_en ? '0 : {sh_n, sv_n, cnt_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= '0;
      stop <= 1'b0;
    end else if (cmd.eval && completes) begin
      fin <= fin_inc;
      if ({fin_inc, 8'b0} > stop_prod) stop <= 1'b1;
    end
  end

  // cordic unit, one rotation per cycle
  logic signed [CW-1:0]      cx, cy, xs, ys;
  logic signed [ANGLE_W-1:0] cz;
  logic [ITER_W-1:0]         iter;
  logic                      neg_x, neg_y;
  logic [SUM_W:0]            ax, ay;
  logic [DIR_W-1:0]          dir_r;

  assign ax = sh_n[SUM_W-1] ? -((SUM_W+1)'(sh_n)) : (SUM_W+1)'(sh_n);
  assign ay = sv_n[SUM_W-1] ? -((SUM_W+1)'(sv_n)) : (SUM_W+1)'(sv_n);
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cx <= CW'({ax, 24'b0});
      cy <= CW'({ay, 24'b0});
      cz <= '0;
      iter <= '0;
      neg_x <= sh_n[SUM_W-1];
      neg_y <= sv_n[SUM_W-1];
    end else if (cmd.cordic_step) begin
      iter <= iter + 1'b1;
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_step(iter);
      end else if (cy < 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_step(iter);
      end
    end
  end

  // angle folding and rounding to 1/64 degree
  logic [ANGLE_W-1:0] zc, ang;
  logic [16:0]        dr, dw;

  always_comb begin
    if (cz < 0) zc = '0;
    else if ($unsigned(cz) > QUARTER) zc = QUARTER;
    else zc = $unsigned(cz);
    priority if (!neg_x && !neg_y) ang = zc;
    else if (neg_x && !neg_y) ang = (QUARTER << 1) - zc;
    else if (neg_x) ang = (QUARTER << 1) + zc;
    else ang = (QUARTER << 2) - zc;
    dr = 17'((33'(ang) + 33'd32768) >> 16);
    dw = (dr >= TURN_UNITS) ? dr - TURN_UNITS : dr;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cls_r <= cls_eval;
      dir_r <= '0;
    end else if (cmd.finish) begin
      dir_r <= DIR_W'(dw);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_class <= cls_r;
      direction <= dir_r;
      road_cells_finished <= fin;
      stop_reached <= stop;
    end
  end

  assign status.clear_done  = (clr_addr == ADDR_W'(CELLS - 1));
  assign status.need_dir    = known;
  assign status.cordic_done = (cy == 0) || (iter == ITER_W'(CORDIC_STEPS - 1));
  assign status.out_free    = !out_valid || !out_stall;

endmodule

@@ sv/gfda_checker.sv @@
// port-level checker for grid_flow_direction_accumulator_core, attached by bind
// depends on gfda_pkg and grid_flow_direction_accumulator_core_macros.svh
`include "grid_flow_direction_accumulator_core_macros.svh"

module gfda_checker import gfda_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       cell_class,
  input logic [DIR_W-1:0] direction,
  input logic             stop_reached
);

  `GFDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(direction) && $stable(cell_class), "stalled result beat changed")
  `GFDA_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second beat taken while an item is in work")
  `GFDA_ASSERT_NEXT(a_stop_sticky, stop_reached, stop_reached, "stop flag dropped")
  `GFDA_ASSERT_IMP(a_dir_only_known, out_valid && (cell_class != CLS_KNOWN), direction == '0, "direction given without known class")

endmodule

bind grid_flow_direction_accumulator_core gfda_checker u_checker (.*);
